/* hw/rtl/hssd_pkg.sv */
// Shared types, constants and the half-step phase table of the stepper driver.
`timescale 1ns / 1ps
`default_nettype none

package hssd_pkg;

    localparam int unsigned POS_W   = 15;
    localparam int unsigned STEPS_W = 16;
    localparam int unsigned TICK_W  = 32;
    localparam int unsigned HOLD_W  = 16;
    localparam int unsigned LEVEL_W = 8;
    localparam int unsigned ADDR_W  = 4;

    localparam logic [LEVEL_W-1:0] FULL_LEVEL = 8'd255;
    localparam logic [LEVEL_W-1:0] HOLD_LEVEL = 8'd128;
    localparam logic [LEVEL_W-1:0] OFF_LEVEL  = 8'd0;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_STEP_GAP   = 2'd0;
    localparam logic [1:0] REG_HOLD_LIMIT = 2'd1;
    localparam logic [1:0] REG_STEPS_TURN = 2'd2;

    localparam logic [TICK_W-1:0] STEP_GAP_RST   = 32'd1000;
    localparam logic [HOLD_W-1:0] HOLD_LIMIT_RST = 16'hFFFF;
    localparam logic [POS_W-1:0]  STEPS_TURN_RST = 15'd400;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_MOVE = 1'b1;

    typedef struct packed {
        logic [TICK_W-1:0] step_gap;
        logic [HOLD_W-1:0] hold_limit;
        logic [POS_W-1:0]  steps_turn;
    } t_cfg;

    typedef struct packed {
        logic               dir_a;
        logic               dir_b;
        logic [LEVEL_W-1:0] pwm_a_level;
        logic [LEVEL_W-1:0] pwm_b_level;
        logic               busy_res;
        logic               stepped;
        logic [POS_W-1:0]   position;
    } t_result;

    // Lines per phase: dirA in bit 3, dirB in bit 2, pwmA in bit 1, pwmB in bit 0.
    function automatic logic [3:0] phase_lines(input logic [2:0] phase);
        logic [3:0] lines;
        case (phase)
            3'd0:    lines = 4'hE;
            3'd1:    lines = 4'hF;
            3'd2:    lines = 4'h5;
            3'd3:    lines = 4'h7;
            3'd4:    lines = 4'h2;
            3'd5:    lines = 4'h3;
            3'd6:    lines = 4'h9;
            3'd7:    lines = 4'hB;
            default: lines = 4'h0;
        endcase
        return lines;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/hssd_in_if.sv */
// Input item channel of the stepper driver: command and signed step count.
`timescale 1ns / 1ps
`default_nettype none

interface hssd_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  command;
    logic signed [hssd_pkg::STEPS_W-1:0]   move_steps;

    modport source (output valid, output command, output move_steps, input ready);
    modport sink (input valid, input command, input move_steps, output ready);
endinterface

`default_nettype wire

/* hw/rtl/hssd_out_if.sv */
// Result item channel of the stepper driver: coil lines, levels and status.
`timescale 1ns / 1ps
`default_nettype none

interface hssd_out_if;
    logic                           valid;
    logic                           ready;
    logic                           dir_a;
    logic                           dir_b;
    logic [hssd_pkg::LEVEL_W-1:0]   pwm_a_level;
    logic [hssd_pkg::LEVEL_W-1:0]   pwm_b_level;
    logic                           busy_res;
    logic                           stepped;
    logic [hssd_pkg::POS_W-1:0]     position;

    modport source (
        output valid, output dir_a, output dir_b, output pwm_a_level,
        output pwm_b_level, output busy_res, output stepped, output position,
        input ready
    );
    modport sink (
        input valid, input dir_a, input dir_b, input pwm_a_level,
        input pwm_b_level, input busy_res, input stepped, input position,
        output ready
    );
endinterface

`default_nettype wire

/* hw/rtl/hssd_cfg.sv */
// APB-style configuration registers of the stepper driver.
`timescale 1ns / 1ps
`default_nettype none

module hssd_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [hssd_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    output hssd_pkg::t_cfg                     o_cfg
);

    hssd_pkg::t_cfg r_cfg;
    logic           w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_gap   <= hssd_pkg::STEP_GAP_RST;
            r_cfg.hold_limit <= hssd_pkg::HOLD_LIMIT_RST;
            r_cfg.steps_turn <= hssd_pkg::STEPS_TURN_RST;
        end else if (w_wr) begin
            case (paddr[3:2])
                hssd_pkg::REG_STEP_GAP:   r_cfg.step_gap <= pwdata;
                hssd_pkg::REG_HOLD_LIMIT: r_cfg.hold_limit <= pwdata[hssd_pkg::HOLD_W-1:0];
                hssd_pkg::REG_STEPS_TURN: r_cfg.steps_turn <= pwdata[hssd_pkg::POS_W-1:0];
                default: ;
            endcase
        end
    end

    // Unaligned and unmapped reads return zero.
    always_comb begin
        prdata = 32'd0;
        if (paddr[1:0] == 2'd0) begin
            case (paddr[3:2])
                hssd_pkg::REG_STEP_GAP:   prdata = r_cfg.step_gap;
                hssd_pkg::REG_HOLD_LIMIT: prdata = {16'd0, r_cfg.hold_limit};
                hssd_pkg::REG_STEPS_TURN: prdata = {17'd0, r_cfg.steps_turn};
                default:                  prdata = 32'd0;
            endcase
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/hssd_step.sv */
// Motion state of the stepper driver and the next-state and result logic per item.
`timescale 1ns / 1ps
`default_nettype none

module hssd_step (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_accept,
    input  wire logic                                 i_command,
    input  wire logic signed [hssd_pkg::STEPS_W-1:0]  i_move_steps,
    input  wire hssd_pkg::t_cfg                       i_cfg,
    output hssd_pkg::t_result                         o_result
);

    logic [hssd_pkg::POS_W-1:0]   r_pos,   n_pos;
    logic                         r_fwd,   n_fwd;
    logic [hssd_pkg::STEPS_W-1:0] r_rem,   n_rem;
    logic [hssd_pkg::TICK_W-1:0]  r_ticks, n_ticks;
    logic [3:0]                   r_lines, n_lines;
    logic                         r_hold,  n_hold;

    logic [hssd_pkg::TICK_W-1:0]  w_ticks_inc;
    logic [hssd_pkg::POS_W-1:0]   w_pos_up;
    logic [hssd_pkg::POS_W-1:0]   w_pos_dn_base;
    logic [hssd_pkg::POS_W-1:0]   w_pos_step;
    logic [hssd_pkg::STEPS_W-1:0] w_raw;
    logic                         w_due;
    logic                         w_stepped;

    assign w_raw       = i_move_steps;
    assign w_ticks_inc = (r_ticks == '1) ? r_ticks : r_ticks + 1'b1;
    assign w_due       = (r_rem != '0) && (w_ticks_inc >= i_cfg.step_gap);

    // Forward wraps at the revolution count (or at the 15-bit boundary when the
    // position has run past it); reverse from zero goes to the last step.
    assign w_pos_up      = (r_pos + 1'b1 == i_cfg.steps_turn) ? '0 : r_pos + 1'b1;
    assign w_pos_dn_base = (r_pos == '0) ? i_cfg.steps_turn : r_pos;
    assign w_pos_step    = r_fwd ? w_pos_up : w_pos_dn_base - 1'b1;

    always_comb begin
        n_pos     = r_pos;
        n_fwd     = r_fwd;
        n_rem     = r_rem;
        n_ticks   = r_ticks;
        n_lines   = r_lines;
        n_hold    = r_hold;
        w_stepped = 1'b0;
        if (i_command == hssd_pkg::CMD_MOVE) begin
            if (w_raw != '0) begin
                n_fwd = !w_raw[hssd_pkg::STEPS_W-1];
                n_rem = w_raw[hssd_pkg::STEPS_W-1] ? ('0 - w_raw) : w_raw;
            end
        end else begin
            n_ticks = w_ticks_inc;
            if (w_due) begin
                n_ticks   = '0;
                n_pos     = w_pos_step;
                n_rem     = r_rem - 1'b1;
                n_lines   = hssd_pkg::phase_lines(w_pos_step[2:0]);
                n_hold    = 1'b0;
                w_stepped = 1'b1;
            end else if ((r_rem != '0) &&
                         (w_ticks_inc >= {16'd0, i_cfg.hold_limit})) begin
                n_hold = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_fwd   <= 1'b0;
            r_rem   <= '0;
            r_ticks <= '1;
            r_lines <= '0;
            r_hold  <= 1'b0;
        end else if (i_accept) begin
            r_pos   <= n_pos;
            r_fwd   <= n_fwd;
            r_rem   <= n_rem;
            r_ticks <= n_ticks;
            r_lines <= n_lines;
            r_hold  <= n_hold;
        end
    end

    // The result reflects the state as this item leaves it.
    always_comb begin
        o_result.dir_a       = n_lines[3];
        o_result.dir_b       = n_lines[2];
        o_result.pwm_a_level = n_hold ? hssd_pkg::HOLD_LEVEL :
                               (n_lines[1] ? hssd_pkg::FULL_LEVEL : hssd_pkg::OFF_LEVEL);
        o_result.pwm_b_level = n_hold ? hssd_pkg::HOLD_LEVEL :
                               (n_lines[0] ? hssd_pkg::FULL_LEVEL : hssd_pkg::OFF_LEVEL);
        o_result.busy_res    = (n_rem != '0);
        o_result.stepped     = w_stepped;
        o_result.position    = n_pos;
    end

endmodule

`default_nettype wire

/* hw/rtl/half_step_stepper_driver_core.sv */
// Top level of the half-step stepper driver: config port, motion state, result register.
`timescale 1ns / 1ps
`default_nettype none

// Each input item (a one-microsecond tick or a move command) yields exactly one
// result item, and the block takes one item per clock cycle: the tick count,
// step decision, position wrap and phase lookup settle in one pass of logic
// between the motion state registers and the result register. The result
// register frees in the same cycle that its item is taken, so input is ready
// whenever the result is empty or being taken; a stalled result holds input
// off. Configuration writes land at byte addresses 0, 4 and 8 and should be
// made only while no item is in flight.
module half_step_stepper_driver_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    hssd_in_if.sink                            i_item,
    hssd_out_if.source                         o_result,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [hssd_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready
);

    hssd_pkg::t_cfg    w_cfg;
    hssd_pkg::t_result w_next;
    hssd_pkg::t_result r_res;
    logic              r_valid;
    logic              w_accept;

    assign i_item.ready = !r_valid || o_result.ready;
    assign w_accept     = i_item.valid && i_item.ready;

    hssd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    hssd_step u_step (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_command    (i_item.command),
        .i_move_steps (i_item.move_steps),
        .i_cfg        (w_cfg),
        .o_result     (w_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res <= w_next;
        end
    end

    assign o_result.valid       = r_valid;
    assign o_result.dir_a       = r_res.dir_a;
    assign o_result.dir_b       = r_res.dir_b;
    assign o_result.pwm_a_level = r_res.pwm_a_level;
    assign o_result.pwm_b_level = r_res.pwm_b_level;
    assign o_result.busy_res    = r_res.busy_res;
    assign o_result.stepped     = r_res.stepped;
    assign o_result.position    = r_res.position;

endmodule

`default_nettype wire
